### hw/rtl/usb_endpoint_context_fields_defines.svh
// Assertion helpers for the endpoint context mapper.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef USB_ENDPOINT_CONTEXT_FIELDS_DEFINES_SVH
`define USB_ENDPOINT_CONTEXT_FIELDS_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define UCX_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("endpoint context check failed");

// Next-cycle implication, checked only outside reset.
`define UCX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("endpoint context sequencing check failed");

`endif

### hw/rtl/usbctx_pkg.sv
package usbctx_pkg;

	typedef enum logic [1:0] {
		SPEED_LOW   = 2'd0,
		SPEED_FULL  = 2'd1,
		SPEED_HIGH  = 2'd2,
		SPEED_SUPER = 2'd3
	} speed_t;

	typedef logic [1:0] ep_type_t;
	localparam ep_type_t EP_CONTROL = 2'd0;
	localparam ep_type_t EP_ISOCH   = 2'd1;
	localparam ep_type_t EP_BULK    = 2'd2;
	localparam ep_type_t EP_INTR    = 2'd3;

	typedef logic [2:0] ep_kind_t;
	localparam ep_kind_t KIND_INVALID = 3'd0;
	localparam ep_kind_t KIND_CONTROL = 3'd4;

	localparam logic [15:0] PERIODIC_SIZE_MASK = 16'h07FF;
	localparam logic [15:0] CONTROL_AVG_LEN    = 16'd8;
	localparam logic [1:0]  RETRY_DEFAULT      = 2'd3;
	localparam logic [1:0]  RETRY_ISOCH        = 2'd0;

	typedef struct packed {
		logic [7:0]  endpoint_address;
		logic [7:0]  attributes;
		logic [15:0] max_packet_field;
		logic [7:0]  poll_interval;
	} req_t;

	typedef struct packed {
		logic [4:0]  endpoint_index;
		logic [2:0]  endpoint_kind;
		logic [15:0] packet_size;
		logic [1:0]  burst_count;
		logic [15:0] periodic_payload;
		logic [4:0]  interval_exponent;
		logic [15:0] average_length;
		logic [1:0]  retry_limit;
		logic [31:0] add_flags;
		logic        bad_descriptor;
	} rsp_t;

endpackage

### hw/rtl/usbctx_interval.sv
module usbctx_interval (
	input  usbctx_pkg::speed_t   speed,
	input  usbctx_pkg::ep_type_t ep_type,
	input  logic [7:0]           poll_interval,
	output logic [4:0]           interval_exponent
);
	import usbctx_pkg::*;

	localparam logic [4:0] IVL_HS_MAX     = 5'd15;
	localparam logic [4:0] IVL_FS_ISO_MIN = 5'd3;
	localparam logic [4:0] IVL_FS_ISO_MAX = 5'd18;
	localparam logic [4:0] IVL_LOG_BIAS   = 5'd3;

	logic       periodic;
	logic       b_zero;
	logic [2:0] lg;
	logic [7:0] b_m1;
	logic [4:0] wrapped;
	logic [4:0] fs_iso;
	logic [4:0] log_rule;
	logic [4:0] hs_async;

	// Highest set bit of the polling interval.
	always_comb begin
		lg = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (poll_interval[i]) begin
				lg = 3'(i);
			end
		end
	end

	assign periodic = (ep_type == EP_ISOCH) || (ep_type == EP_INTR);
	assign b_zero   = (poll_interval == 8'd0);
	assign b_m1     = poll_interval - 8'd1;

	// A zero interval wraps on subtraction and so lands on the clamp.
	assign wrapped  = (b_zero || (b_m1 > 8'(IVL_HS_MAX))) ? IVL_HS_MAX : b_m1[4:0];
	assign fs_iso   = b_zero ? IVL_FS_ISO_MIN :
		((poll_interval >= 8'd16) ? IVL_FS_ISO_MAX : (5'(poll_interval[3:0]) + 5'd2));
	// log2(b*8) never exceeds ten for an 8-bit interval, so only the bias is needed.
	assign log_rule = b_zero ? 5'd0 : ({2'b00, lg} + IVL_LOG_BIAS);
	assign hs_async = b_zero ? 5'd0 : {2'b00, lg};

	always_comb begin
		unique case (speed)
			SPEED_HIGH: begin
				interval_exponent = periodic ? wrapped : hs_async;
			end
			SPEED_SUPER: begin
				interval_exponent = periodic ? wrapped : 5'd0;
			end
			SPEED_FULL: begin
				if (ep_type == EP_ISOCH) begin
					interval_exponent = fs_iso;
				end else begin
					interval_exponent = periodic ? log_rule : 5'd0;
				end
			end
			SPEED_LOW: begin
				interval_exponent = periodic ? log_rule : 5'd0;
			end
		endcase
	end

endmodule

### hw/rtl/usbctx_map.sv
module usbctx_map (
	input  usbctx_pkg::speed_t speed,
	input  usbctx_pkg::req_t   req,
	output usbctx_pkg::rsp_t   rsp
);
	import usbctx_pkg::*;

	ep_type_t    ep_type;
	logic        dir_in;
	logic        ctrl_ep;
	logic        async_type;
	logic [4:0]  index;
	logic [15:0] psize;
	logic [1:0]  burst;
	logic [2:0]  burst_p1;
	logic [18:0] product;
	logic [4:0]  ivl;

	assign ep_type    = req.attributes[1:0];
	assign dir_in     = req.endpoint_address[7];
	assign ctrl_ep    = (ep_type == EP_CONTROL);
	assign async_type = (ep_type == EP_CONTROL) || (ep_type == EP_BULK);
	assign index      = {req.endpoint_address[3:0], dir_in};

	assign psize    = async_type ? req.max_packet_field
		: (req.max_packet_field & PERIODIC_SIZE_MASK);
	assign burst    = async_type ? 2'd0 : req.max_packet_field[12:11];
	assign burst_p1 = {1'b0, burst} + 3'd1;
	assign product  = 19'(psize) * 19'(burst_p1);

	usbctx_interval u_interval (
		.speed             (speed),
		.ep_type           (ep_type),
		.poll_interval     (req.poll_interval),
		.interval_exponent (ivl)
	);

	always_comb begin
		rsp.endpoint_index = index;
		// An OUT control endpoint has no valid type code.
		if (ctrl_ep) begin
			rsp.endpoint_kind = dir_in ? KIND_CONTROL : KIND_INVALID;
		end else begin
			rsp.endpoint_kind = {dir_in, ep_type};
		end
		rsp.packet_size       = psize;
		rsp.burst_count       = burst;
		rsp.periodic_payload  = product[15:0];
		rsp.interval_exponent = ivl;
		rsp.average_length    = ctrl_ep ? CONTROL_AVG_LEN : product[15:0];
		rsp.retry_limit       = (ep_type == EP_ISOCH) ? RETRY_ISOCH : RETRY_DEFAULT;
		rsp.add_flags         = (32'd1 << index) | 32'd1;
		rsp.bad_descriptor    = ctrl_ep && !dir_in;
	end

endmodule

### hw/rtl/usb_endpoint_context_fields.sv
// An accepted request reaches rsp through the input register and the result register.
// Throughput: one request per cycle while req_stall is low; the two registers form
// a two-stage pipeline, so a waiting result stalls the input only when both stages are full.
// Reset: arst_n clears both stage valid bits and sets the device speed to high speed.
`include "usb_endpoint_context_fields_defines.svh"

module usb_endpoint_context_fields (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  usbctx_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output usbctx_pkg::rsp_t  rsp
);
	import usbctx_pkg::*;

	speed_t speed_q;
	logic   valid_s1;
	req_t   req_s1;
	logic   valid_s2;
	rsp_t   rsp_s2;
	rsp_t   rsp_comb;
	logic   adv_s1;
	logic   adv_s2;

	assign adv_s2    = !valid_s2 || !rsp_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= SPEED_HIGH;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_write) begin
				speed_q <= speed_t'(cfg_data);
			end
			if (adv_s1) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	usbctx_map u_map (
		.speed (speed_q),
		.req   (req_s1),
		.rsp   (rsp_comb)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	`UCX_ASSERT_NEXT(a_accept_fills_s1, req_valid && !req_stall, valid_s1)
	`UCX_ASSERT_IMPLY(a_full_pipe_stalls, valid_s1 && valid_s2 && rsp_stall, req_stall)
	`UCX_ASSERT_IMPLY(a_bad_has_no_kind, rsp_valid && rsp.bad_descriptor, rsp.endpoint_kind == KIND_INVALID)
	`UCX_ASSERT_IMPLY(a_flags_base_bit, rsp_valid, rsp.add_flags[0])

endmodule
